// ===== hw/rtl/c1dmp_pkg.sv =====
package c1dmp_pkg;

    localparam int TAP_BITS     = 16;
    localparam int TAP_CNT_W    = 4;
    localparam int POOL_LEN_W   = 8;
    localparam int VALUE_BITS   = 40;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int TAPS_PER_WORD = CFG_DATA_W / TAP_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_LENGTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_LOW    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_HIGH   = 2'd3;

    localparam logic [POOL_LEN_W-1:0] POOL_FILL_MAX = '1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               final_sample;
    } t_in_word;

    typedef struct packed {
        logic                          conv_valid;
        logic signed [VALUE_BITS-1:0]  conv_value;
        logic                          pool_valid;
        logic signed [VALUE_BITS-1:0]  pool_value;
        logic                          sequence_end;
    } t_out_word;

endpackage

// ===== hw/rtl/conv1d_valid_maxpool.sv =====
// channel | direction | handshake                  | word
// in      | input     | i_in_valid / o_in_ready    | t_in_word (sample, final_sample)
// out     | output    | o_out_valid / i_out_ready  | t_out_word (conv, pool, sequence_end)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the output is not stalled; each result passes the s1, s2, s3 and output registers
// stages: window select, tap multipliers (one per tap), sum of products, pool compare + output
// reset is synchronous: tap_count 1, pool_length 1, taps 0, delay line and pool cleared
// a stalled output fills the empty stages first; o_in_ready drops once all four are full
// config writes are taken every cycle (o_cfg_ready is always high)
module conv1d_valid_maxpool #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  c1dmp_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output c1dmp_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [c1dmp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [c1dmp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import c1dmp_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS) + 1;

    // configuration
    logic [TAP_CNT_W-1:0]    r_tap_count;
    logic [POOL_LEN_W-1:0]   r_pool_length;
    logic [CFG_DATA_W-1:0]   r_taps_low;
    logic [CFG_DATA_W-1:0]   r_taps_high;
    logic [2*CFG_DATA_W-1:0] taps_all;

    // sequence state
    logic signed [SAMPLE_BITS-1:0] r_delay [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] n_delay [MAX_TAPS];
    logic [TAP_CNT_W-1:0]          r_seen;
    logic [TAP_CNT_W-1:0]          n_seen;
    logic [TAP_CNT_W-1:0]          seen_inc;
    logic [TAP_CNT_W-1:0]          taps_used;
    logic signed [VALUE_BITS-1:0]  r_pool_max;
    logic signed [VALUE_BITS-1:0]  n_pool_max;
    logic [POOL_LEN_W-1:0]         r_pool_fill;
    logic [POOL_LEN_W-1:0]         n_pool_fill;
    logic [POOL_LEN_W-1:0]         pool_len;

    // pipeline stages
    logic                          r_s1_valid, r_s1_conv, r_s1_last;
    logic signed [SAMPLE_BITS-1:0] r_s1_win [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] n_s1_win [MAX_TAPS];
    logic                          n_s1_conv;
    logic                          r_s2_valid, r_s2_conv, r_s2_last;
    logic signed [PROD_W-1:0]      r_s2_prod [MAX_TAPS];
    logic signed [PROD_W-1:0]      n_s2_prod [MAX_TAPS];
    logic                          r_s3_valid, r_s3_conv, r_s3_last;
    logic signed [SUM_W-1:0]       r_s3_sum;
    logic signed [SUM_W-1:0]       n_s3_sum;
    logic                          r_out_valid;
    t_out_word                     r_out_word;
    t_out_word                     n_out_word;

    logic ld_out, ld3, ld2, ld1, in_acc;
    logic signed [VALUE_BITS-1:0] conv_ext;
    logic signed [VALUE_BITS-1:0] max_upd;
    logic [POOL_LEN_W-1:0]        fill_inc;

    assign ld_out = !r_out_valid || i_out_ready;
    assign ld3    = !r_s3_valid || ld_out;
    assign ld2    = !r_s2_valid || ld3;
    assign ld1    = !r_s1_valid || ld2;
    assign in_acc = i_in_valid && ld1;

    assign o_in_ready  = ld1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    assign taps_all = {r_taps_high, r_taps_low};

    always_comb begin
        if (r_tap_count == '0) begin
            taps_used = TAP_CNT_W'(1);
        end else if (r_tap_count > TAP_CNT_W'(MAX_TAPS)) begin
            taps_used = TAP_CNT_W'(MAX_TAPS);
        end else begin
            taps_used = r_tap_count;
        end
        pool_len = (r_pool_length == '0) ? POOL_LEN_W'(1) : r_pool_length;
    end

    // stage 1: shift in the sample, select the window in tap order
    always_comb begin
        n_delay[0] = i_in_word.sample[SAMPLE_BITS-1:0];
        for (int k = 1; k < MAX_TAPS; k++) begin
            n_delay[k] = r_delay[k-1];
        end
        for (int j = 0; j < MAX_TAPS; j++) begin
            n_s1_win[j] = '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (j < int'(taps_used) && k == int'(taps_used) - 1 - j) begin
                    n_s1_win[j] = n_delay[k];
                end
            end
        end
        seen_inc  = (r_seen < taps_used) ? r_seen + TAP_CNT_W'(1) : r_seen;
        if (seen_inc > taps_used) begin
            seen_inc = taps_used;
        end
        n_s1_conv = (seen_inc >= taps_used);
        n_seen    = i_in_word.final_sample ? '0 : seen_inc;
    end

    // stage 2: one multiplier per tap
    always_comb begin
        for (int j = 0; j < MAX_TAPS; j++) begin
            n_s2_prod[j] = $signed(taps_all[TAP_BITS*j +: TAP_BITS]) * r_s1_win[j];
        end
    end

    // stage 3: sum of products
    always_comb begin
        n_s3_sum = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            n_s3_sum = n_s3_sum + {{(SUM_W-PROD_W){r_s2_prod[j][PROD_W-1]}}, r_s2_prod[j]};
        end
    end

    // output stage: running max and pool emission
    always_comb begin
        conv_ext    = {{(VALUE_BITS-SUM_W){r_s3_sum[SUM_W-1]}}, r_s3_sum};
        max_upd     = (r_pool_fill == '0 || conv_ext > r_pool_max) ? conv_ext : r_pool_max;
        fill_inc    = (r_pool_fill < POOL_FILL_MAX) ? r_pool_fill + POOL_LEN_W'(1)
                                                    : r_pool_fill;
        n_pool_max  = r_pool_max;
        n_pool_fill = r_pool_fill;
        n_out_word  = '0;
        n_out_word.sequence_end = r_s3_last;
        if (r_s3_conv) begin
            n_out_word.conv_valid = 1'b1;
            n_out_word.conv_value = conv_ext;
            if (fill_inc >= pool_len) begin
                n_out_word.pool_valid = 1'b1;
                n_out_word.pool_value = max_upd;
                n_pool_fill = '0;
                n_pool_max  = '0;
            end else begin
                n_pool_fill = fill_inc;
                n_pool_max  = max_upd;
            end
        end
        if (r_s3_last) begin
            if (!n_out_word.pool_valid && n_pool_fill != '0) begin
                n_out_word.pool_valid = 1'b1;
                n_out_word.pool_value = n_pool_max;
            end
            n_pool_fill = '0;
            n_pool_max  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= TAP_CNT_W'(1);
            r_pool_length <= POOL_LEN_W'(1);
            r_taps_low    <= '0;
            r_taps_high   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TAP_COUNT:   r_tap_count   <= i_cfg_data[TAP_CNT_W-1:0];
                REG_POOL_LENGTH: r_pool_length <= i_cfg_data[POOL_LEN_W-1:0];
                REG_TAPS_LOW:    r_taps_low    <= i_cfg_data;
                REG_TAPS_HIGH:   r_taps_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_delay[k] <= '0;
            end
            r_seen      <= '0;
            r_pool_max  <= '0;
            r_pool_fill <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_delay <= n_delay;
                r_seen  <= n_seen;
            end
            if (ld1) begin
                r_s1_valid <= in_acc;
            end
            if (ld2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ld3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (ld_out) begin
                r_out_valid <= r_s3_valid;
                if (r_s3_valid) begin
                    r_pool_max  <= n_pool_max;
                    r_pool_fill <= n_pool_fill;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_win  <= n_s1_win;
            r_s1_conv <= n_s1_conv;
            r_s1_last <= i_in_word.final_sample;
        end
        if (ld2 && r_s1_valid) begin
            r_s2_prod <= n_s2_prod;
            r_s2_conv <= r_s1_conv;
            r_s2_last <= r_s1_last;
        end
        if (ld3 && r_s2_valid) begin
            r_s3_sum  <= n_s3_sum;
            r_s3_conv <= r_s2_conv;
            r_s3_last <= r_s2_last;
        end
        if (ld_out && r_s3_valid) begin
            r_out_word <= n_out_word;
        end
    end

    a_pool_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.pool_valid && !o_out_word.conv_valid
            |-> o_out_word.sequence_end)
        else $error("pool word without correlation outside sequence end");

    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_fill != POOL_FILL_MAX)
        else $error("pool fill reached saturation");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= TAP_CNT_W'(MAX_TAPS))
        else $error("samples seen above tap limit");

    a_stall_holds_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_pool_fill) && $stable(r_pool_max))
        else $error("pool state moved while output stalled");

endmodule
